FILE: hw/rtl/udpcv_pkg.sv
package udpcv_pkg;

    localparam logic [15:0] UDP_PROTO  = 16'h0011;
    localparam logic [15:0] HDR_BYTES  = 16'd8;
    localparam logic [15:0] SUM_ONES   = 16'hFFFF;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;
    localparam logic [15:0] LEN_HI_POS = 16'd4;
    localparam logic [15:0] LEN_LO_POS = 16'd5;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_in_item;

    typedef struct packed {
        logic        checksum_ok;
        logic [15:0] folded_sum;
        logic        length_short;
    } t_out_item;

    // Handoff from the accumulator to the output stage.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

FILE: hw/rtl/udpcv_accum.sv
module udpcv_accum
    import udpcv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_result  o_result
);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_len, n_len;

    logic        first;
    logic        counted;
    logic [15:0] len_cur;
    logic [7:0]  held_cur;
    logic [15:0] word_term;
    logic [15:0] len_term;
    logic [15:0] pad_term;
    logic [18:0] base;
    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] folded;
    logic [15:0] eff;
    logic [16:0] received;
    logic [16:0] count;

    always_comb begin
        first    = (r_pos == '0);
        len_cur  = first ? '0 : r_len;
        held_cur = first ? '0 : r_held;
        counted  = (r_pos < HDR_BYTES) || (r_pos < len_cur);

        n_held = held_cur;
        word_term = '0;
        if (counted) begin
            if (!r_pos[0]) begin
                n_held = i_item.data_byte;
            end else begin
                word_term = {held_cur, i_item.data_byte};
            end
        end

        n_len = len_cur;
        len_term = '0;
        if (r_pos == LEN_HI_POS) begin
            n_len = {i_item.data_byte, 8'h00};
        end else if (r_pos == LEN_LO_POS) begin
            n_len    = {len_cur[15:8], i_item.data_byte};
            len_term = n_len;
        end

        eff      = (n_len < HDR_BYTES) ? HDR_BYTES : n_len;
        received = {1'b0, r_pos} + 17'd1;
        count    = counted ? received : {1'b0, eff};
        // Pad an odd final counted byte with a zero low byte.
        pad_term = (i_item.last && count[0]) ? {n_held, 8'h00} : '0;

        // Start of a datagram: seed with the pseudo-header addresses and protocol.
        if (first) begin
            base = {3'b000, i_item.src_ip[31:16]} + {3'b000, i_item.src_ip[15:0]}
                 + {3'b000, i_item.dst_ip[31:16]} + {3'b000, i_item.dst_ip[15:0]}
                 + {3'b000, UDP_PROTO};
        end else begin
            base = {3'b000, r_sum};
        end

        total  = base + {3'b000, word_term} + {3'b000, len_term} + {3'b000, pad_term};
        fold1  = {1'b0, total[15:0]} + {14'b0, total[18:16]};
        folded = fold1[15:0] + {15'b0, fold1[16]};

        if (i_item.last) begin
            n_sum  = '0;
            n_pos  = '0;
            n_held = '0;
            n_len  = '0;
        end else begin
            n_sum = folded;
            n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
        end

        o_result.valid             = i_fire && i_item.last;
        o_result.item.folded_sum   = folded;
        o_result.item.checksum_ok  = (folded == SUM_ONES);
        o_result.item.length_short = (received < {1'b0, eff});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_held <= '0;
            r_len  <= '0;
        end else if (i_fire) begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_held <= n_held;
            r_len  <= n_len;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.last |=> r_pos == '0)
        else $error("position not cleared after last byte");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.last && r_pos != POS_MAX |=> r_pos == $past(r_pos) + 16'd1)
        else $error("byte position did not advance");

    a_len_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.last && r_pos > LEN_LO_POS |=> $stable(r_len))
        else $error("length changed after header");

endmodule

FILE: hw/rtl/udpcv_out_stage.sv
module udpcv_out_stage
    import udpcv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_result,
    input  logic      i_out_stall,
    output logic      o_can_take,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;

    // Slot frees when empty or when its item leaves this cycle.
    assign o_can_take  = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_result.valid) begin
            r_data <= i_result.item;
        end
    end

endmodule

FILE: hw/rtl/udp_checksum_verifier.sv
// UDP checksum verifier with IPv4 pseudo-header.
// Input channel (i_in_valid / o_in_stall / i_in_data): one datagram byte per
// item, UDP header first; src_ip and dst_ip are sampled with the first byte
// and last marks the final byte. Output channel (o_out_valid / i_out_stall /
// o_out_data): one item per datagram carrying the folded ones complement sum,
// checksum_ok and length_short.
// Throughput: one byte per cycle while no last byte waits for the result
// slot, set by the single 16-bit accumulate stage between the input register
// and the result register. A last byte passes from the input register through
// the accumulate stage into the result register, where its result is taken.
// Reset (synchronous, active low) empties both registers and returns the
// accumulator to the start of a datagram.
// When the receiver stalls, bytes that produce no result keep flowing; a
// last byte waits in the input register until the result slot frees, and
// o_in_stall rises only while it waits.
module udp_checksum_verifier
    import udpcv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic     r_in_valid;
    t_in_item r_in_data;
    logic     can_take;
    logic     consume;
    t_result  result;

    // Advance the held byte unless it is a last byte facing a full result slot.
    assign consume    = r_in_valid && (!r_in_data.last || can_take);
    assign o_in_stall = r_in_valid && !consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Hold the payload while stalled; load a new item otherwise.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    udpcv_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (consume),
        .i_item   (r_in_data),
        .o_result (result)
    );

    udpcv_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_can_take  (can_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: verif/tb.sv
module tb;
    import udpcv_pkg::*;

    // Give up after this many cycles in which neither channel moves an item.
    localparam int STALL_LIMIT = 2000;
    // Let the pipeline drain this many cycles after the last result.
    localparam int TAIL_CYCLES = 8;
    // Idle or stall in this many cycles of a hundred.
    localparam int IDLE_PCT    = 29;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Turn off idling on both sides while set.
    logic calm = 1'b0;

    // Results still owed by the block, oldest first.
    t_out_item sums_due[$];

    // Shadow of the datagram accumulator.
    logic [15:0] acc_sum   = '0;
    logic [15:0] byte_pos  = '0;
    logic [7:0]  hi_byte   = '0;
    logic [15:0] dgram_len = '0;

    int n_fail    = 0;
    int n_bytes   = 0;
    int n_results = 0;
    int n_ok      = 0;
    int n_short   = 0;

    wire in_take  = i_in_valid && !o_in_stall;
    wire out_take = o_out_valid && !i_out_stall;

    udp_checksum_verifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Fold carries end-around down to 16 bits.
    function automatic logic [15:0] ones_fold(input logic [31:0] x);
        logic [31:0] y;
        y = 32'(x[15:0]) + 32'(x[31:16]);
        y = 32'(y[15:0]) + 32'(y[31:16]);
        return y[15:0];
    endfunction

    function automatic void flag_error(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Advance the shadow accumulator by one accepted byte; queue the result
    // owed when the byte closes a datagram.
    function automatic void accum_byte(input t_in_item it);
        logic [15:0] pos;
        logic        counted;
        logic [16:0] received;
        logic [16:0] eff;
        logic [16:0] cnt;
        logic [15:0] s;
        t_out_item   res;
        pos = byte_pos;
        // Seed the sum with the addresses and protocol of the pseudo-header.
        if (pos == 16'd0) begin
            acc_sum   = ones_fold(32'(it.src_ip[31:16]) + 32'(it.src_ip[15:0]) +
                                  32'(it.dst_ip[31:16]) + 32'(it.dst_ip[15:0]) +
                                  32'(UDP_PROTO));
            dgram_len = '0;
            hi_byte   = '0;
        end
        // The header is always summed, whatever its length field says.
        counted = (pos < HDR_BYTES) || (pos < dgram_len);
        if (counted) begin
            if (!pos[0])
                hi_byte = it.data_byte;
            else
                acc_sum = ones_fold(32'(acc_sum) + 32'({hi_byte, it.data_byte}));
        end
        if (pos == LEN_HI_POS) begin
            dgram_len = {it.data_byte, 8'h00};
        end else if (pos == LEN_LO_POS) begin
            dgram_len = dgram_len | 16'(it.data_byte);
            acc_sum   = ones_fold(32'(acc_sum) + 32'(dgram_len));
        end
        if (!it.last) begin
            if (byte_pos != POS_MAX)
                byte_pos = byte_pos + 16'd1;
            return;
        end
        eff      = (dgram_len < HDR_BYTES) ? 17'(HDR_BYTES) : 17'(dgram_len);
        received = 17'(pos) + 17'd1;
        cnt      = counted ? received : eff;
        s        = acc_sum;
        // Pad an odd final byte with a zero low byte.
        if (cnt[0])
            s = ones_fold(32'(s) + 32'({hi_byte, 8'h00}));
        res.checksum_ok  = (s == SUM_ONES);
        res.folded_sum   = s;
        res.length_short = (received < eff);
        sums_due.push_back(res);
        acc_sum   = '0;
        byte_pos  = '0;
        hi_byte   = '0;
        dgram_len = '0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_take)
            accum_byte(i_in_data);
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && out_take) begin
            n_results++;
            if (sums_due.size() == 0) begin
                flag_error($sformatf("unexpected result: sum %h ok %b short %b",
                                     o_out_data.folded_sum, o_out_data.checksum_ok,
                                     o_out_data.length_short));
            end else begin
                want = sums_due.pop_front();
                if (o_out_data.folded_sum !== want.folded_sum ||
                    o_out_data.checksum_ok !== want.checksum_ok ||
                    o_out_data.length_short !== want.length_short)
                    flag_error($sformatf({"result %0d: expected sum %h ok %b short %b, ",
                                          "got sum %h ok %b short %b"}, n_results,
                                         want.folded_sum, want.checksum_ok,
                                         want.length_short, o_out_data.folded_sum,
                                         o_out_data.checksum_ok,
                                         o_out_data.length_short));
                if (want.checksum_ok)
                    n_ok++;
                if (want.length_short)
                    n_short++;
            end
        end
    end

    // Stall the result side at random unless calm.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // End the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (in_take || out_take)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    // Present one byte, idling first at random, and hold it until taken.
    task automatic send_item(input t_in_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        n_bytes++;
    endtask

    // Build and send one datagram of n bytes. Write the length field into
    // bytes 4 and 5 where they exist; fill the rest with fill, or at random
    // when fill is negative. With fix set and enough bytes present, choose
    // bytes 6 and 7 so that the checksum comes out good.
    task automatic send_datagram(input int n, input logic [15:0] len, input logic fix,
                                 input int fill, input logic [31:0] src,
                                 input logic [31:0] dst);
        logic [7:0]  pkt[$];
        logic [15:0] s;
        logic [15:0] csum;
        int          eff;
        int          i;
        t_in_item    it;
        for (i = 0; i < n; i++)
            pkt.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        if (n > 4)
            pkt[4] = len[15:8];
        if (n > 5)
            pkt[5] = len[7:0];
        eff = (len < HDR_BYTES) ? int'(HDR_BYTES) : int'(len);
        if (fix && n >= eff) begin
            pkt[6] = 8'h00;
            pkt[7] = 8'h00;
            s = ones_fold(32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) +
                          32'(dst[15:0]) + 32'(UDP_PROTO) + 32'(len));
            for (i = 0; i < eff; i += 2)
                s = ones_fold(32'(s) +
                              32'({pkt[i], (i + 1 < eff) ? pkt[i + 1] : 8'h00}));
            csum   = ~s;
            pkt[6] = csum[15:8];
            pkt[7] = csum[7:0];
        end
        for (i = 0; i < n; i++) begin
            it.data_byte = pkt[i];
            it.last      = (i == n - 1);
            // Scramble the addresses past the first byte: the block must ignore them.
            it.src_ip    = (i == 0) ? src : $urandom;
            it.dst_ip    = (i == 0) ? dst : $urandom;
            send_item(it);
        end
    endtask

    // Pick one datagram shape: mostly well-formed with a good checksum,
    // the rest corrupted, truncated, padded with trailing bytes, or
    // carrying a short or random length field.
    task automatic send_random_datagram();
        int          pick;
        int          n;
        logic [15:0] len;
        logic        fix;
        pick = $urandom_range(99);
        len  = 16'($urandom_range(24, 8));
        n    = int'(len);
        fix  = 1'b1;
        if (pick < 12) begin
            fix = 1'b0;
        end else if (pick < 22) begin
            n = $urandom_range(int'(len) - 1, 1);
        end else if (pick < 32) begin
            n = int'(len) + $urandom_range(6, 1);
        end else if (pick < 40) begin
            len = 16'($urandom_range(7, 0));
            n   = $urandom_range(12, 1);
        end else if (pick < 45) begin
            len = 16'($urandom);
            n   = $urandom_range(20, 1);
        end
        send_datagram(n, len, fix, -1, $urandom, $urandom);
    endtask

    // Cover the corner cases by hand: a one-byte datagram, one that stops
    // before its length is known, a length field below the header size,
    // and an odd length followed by bytes past the end.
    task automatic test_corner_datagrams();
        send_datagram(1, 16'h0000, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_datagram(4, 16'h0000, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_datagram(8, 16'h0005, 1'b1, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_datagram(11, 16'h0009, 1'b1, -1, $urandom, $urandom);
    endtask

    // Stream datagrams with neither side idling.
    task automatic test_back_to_back();
        int start;
        start = n_bytes;
        calm <= 1'b1;
        while (n_bytes - start < 100)
            send_random_datagram();
        calm <= 1'b0;
    endtask

    // Stream random datagrams with idling and stalls on both sides.
    task automatic test_random_traffic();
        int start;
        start = n_bytes;
        while (n_bytes - start < 600)
            send_random_datagram();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_datagrams();
        test_back_to_back();
        test_random_traffic();

        // Drop valid, wait for every owed result, then drain.
        i_in_valid <= 1'b0;
        while (sums_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d datagrams (%0d with a good checksum, %0d cut short),",
                 n_bytes, n_results, n_ok, n_short);
        $display("mixing truncated, padded and odd-length datagrams, with and without stalls.");
        if (n_fail == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/udpcv_pkg.sv
hw/rtl/udpcv_accum.sv
hw/rtl/udpcv_out_stage.sv
hw/rtl/udp_checksum_verifier.sv
verif/tb.sv
